FILE: design/dda_pkg.sv
package dda_pkg;

  // Fixed field widths
  localparam int unsigned COORD_W   = 12;
  localparam int unsigned COLOR_W   = 32;
  localparam int unsigned DIM_W     = 11;
  localparam int unsigned CFG_IDX_W = 2;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_STEPS_DEF = 63;
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Register reset values
  localparam logic [DIM_W-1:0] SCREEN_W_RST = DIM_W'(800);
  localparam logic [DIM_W-1:0] SCREEN_H_RST = DIM_W'(600);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV_X,
    ST_DIV_Y,
    ST_WALK
  } dda_state_e;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: design/dda_div.sv
// Restoring divider: (mag << FRAC_BITS) / divisor, one quotient bit per cycle.
module dda_div import dda_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
  localparam int unsigned DW       = COORD_W + FRAC_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [COORD_W-1:0] mag_i,
  input  logic [COORD_W-1:0] divisor_i,
  output div_stat_t          stat_o,
  output logic [DW-1:0]      quot_o
);

  localparam int unsigned CW = $clog2(DW);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [COORD_W-1:0] rem_q, rem_d;
  logic [COORD_W-1:0] dvs_q, dvs_d;
  logic [DW-1:0]      quo_q, quo_d;
  logic [COORD_W:0]   trial;
  logic               ge;

  assign trial = {rem_q, quo_q[DW-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = {mag_i, {FRAC_BITS{1'b0}}};
    end else if (busy_q) begin
      rem_d = ge ? COORD_W'(trial - {1'b0, dvs_q}) : trial[COORD_W-1:0];
      quo_d = {quo_q[DW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(DW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quo_q;

endmodule

FILE: design/dda_line_rasterizer_core.sv
// DDA line rasterizer.
// Line requests come in on in_valid_i / in_stall_o with two end points and a
// color; pixel requests leave on out_valid_o / out_stall_i, one per pixel.
// Screen size registers are written through cfg_valid_i / cfg_ready_o
// (index 0 width, index 1 height); ready is always high, write only when idle.
// Per line: one prep state forms deltas and steps, then the shared divider
// runs twice (x then y increment), each run ending with a one-cycle done
// strobe. Then one pixel per cycle while the output is not stalled,
// steps+1 pixels, capped at MAX_STEPS+1. The divider's one-bit-per-cycle loop
// sets the setup time; the single output register sets the walk rate.
// A zero-length line goes from prep straight back to idle and emits nothing.
// in_stall_o is high from accept until the last pixel sits in the output reg.
// When out_stall_i is high while the output register holds a pixel, the walk
// freezes and that pixel holds. Reset returns to idle, drops out_valid_o and
// restores the screen size to 800x600.
module dda_line_rasterizer_core import dda_pkg::*; #(
  parameter int unsigned MAX_STEPS = MAX_STEPS_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // line request channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic signed [COORD_W-1:0] start_x_i,
  input  logic signed [COORD_W-1:0] start_y_i,
  input  logic signed [COORD_W-1:0] end_x_i,
  input  logic signed [COORD_W-1:0] end_y_i,
  input  logic [COLOR_W-1:0]    line_color_i,
  // pixel request channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [COORD_W-1:0] pixel_x_o,
  output logic signed [COORD_W-1:0] pixel_y_o,
  output logic [COLOR_W-1:0]    pixel_color_o,
  output logic                  on_screen_o,
  output logic                  last_pixel_o,
  output logic                  cut_short_o,
  // register write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [DIM_W-1:0]      cfg_data_i
);

  localparam int unsigned DW  = COORD_W + FRAC_BITS;      // quotient width
  localparam int unsigned PW  = COORD_W + 1 + FRAC_BITS;  // fixed-point position
  localparam int unsigned SLW = $clog2(MAX_STEPS + 1);

  dda_state_e state_q, state_d;

  // config
  logic [DIM_W-1:0] width_q, height_q;

  // captured request
  logic signed [COORD_W-1:0] sx_q, sy_q, ex_q, ey_q;
  logic [COLOR_W-1:0]        color_q;

  // walk state
  logic signed [PW-1:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic signed [PW-1:0] inc_x_q, inc_x_d, inc_y_q, inc_y_d;
  logic [SLW-1:0]       left_q, left_d;
  logic                 cut_q, cut_d;
  logic                 neg_x_q, neg_x_d, neg_y_q, neg_y_d;
  logic [COORD_W-1:0]   ady_q, ady_d, steps_q, steps_d;

  // output register
  logic                      ovalid_q, ovalid_d;
  logic signed [COORD_W-1:0] px_q, py_q;
  logic [COLOR_W-1:0]        pcol_q;
  logic                      on_q, last_q, cutout_q;
  logic                      load;

  // prep datapath
  logic signed [COORD_W:0] dx, dy;
  logic [COORD_W-1:0]      adx, ady, steps;

  // divider
  logic               div_start;
  logic [COORD_W-1:0] div_mag;
  div_stat_t          div_stat;
  logic [DW-1:0]      div_q;
  logic signed [PW-1:0] div_inc;
  logic               div_neg;

  // pixel from position
  logic signed [COORD_W-1:0] cur_px, cur_py;
  logic                      cur_on, cur_last;

  function automatic logic signed [COORD_W-1:0] trunc_pos(logic signed [PW-1:0] p);
    logic signed [PW-FRAC_BITS-1:0] fl;
    logic                           up;
    fl = (PW-FRAC_BITS)'(p >>> FRAC_BITS);
    up = p[PW-1] && (p[FRAC_BITS-1:0] != '0);
    return COORD_W'(fl + (PW-FRAC_BITS)'(up));
  endfunction

  assign dx    = {ex_q[COORD_W-1], ex_q} - {sx_q[COORD_W-1], sx_q};
  assign dy    = {ey_q[COORD_W-1], ey_q} - {sy_q[COORD_W-1], sy_q};
  assign adx   = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
  assign ady   = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
  assign steps = (adx > ady) ? adx : ady;

  assign div_inc = div_neg ? -PW'({1'b0, div_q}) : PW'({1'b0, div_q});

  assign cur_px   = trunc_pos(pos_x_q);
  assign cur_py   = trunc_pos(pos_y_q);
  assign cur_on   = !cur_px[COORD_W-1] && !cur_py[COORD_W-1] &&
                    (cur_px[DIM_W-1:0] < width_q) && (cur_py[DIM_W-1:0] < height_q);
  assign cur_last = (left_q == '0);

  // output register free or emptying this cycle
  assign load = (state_q == ST_WALK) && (!ovalid_q || !out_stall_i);

  always_comb begin
    state_d   = state_q;
    pos_x_d   = pos_x_q;
    pos_y_d   = pos_y_q;
    inc_x_d   = inc_x_q;
    inc_y_d   = inc_y_q;
    left_d    = left_q;
    cut_d     = cut_q;
    neg_x_d   = neg_x_q;
    neg_y_d   = neg_y_q;
    ady_d     = ady_q;
    steps_d   = steps_q;
    div_start = 1'b0;
    div_mag   = ady_q;
    div_neg   = neg_x_q;
    ovalid_d  = ovalid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_PREP;
      end
      ST_PREP: begin
        if (steps == '0) begin
          state_d = ST_IDLE;
        end else begin
          // start position: start point in fixed point, no fraction
          pos_x_d   = {sx_q[COORD_W-1], sx_q, {FRAC_BITS{1'b0}}};
          pos_y_d   = {sy_q[COORD_W-1], sy_q, {FRAC_BITS{1'b0}}};
          neg_x_d   = dx[COORD_W];
          neg_y_d   = dy[COORD_W];
          ady_d     = ady;
          steps_d   = steps;
          cut_d     = steps > COORD_W'(MAX_STEPS);
          left_d    = (steps > COORD_W'(MAX_STEPS)) ? SLW'(MAX_STEPS) : steps[SLW-1:0];
          div_start = 1'b1;
          div_mag   = adx;
          state_d   = ST_DIV_X;
        end
      end
      ST_DIV_X: begin
        if (div_stat.done) begin
          inc_x_d   = div_inc;
          div_start = 1'b1;
          div_mag   = ady_q;
          state_d   = ST_DIV_Y;
        end
      end
      ST_DIV_Y: begin
        div_neg = neg_y_q;
        if (div_stat.done) begin
          inc_y_d = div_inc;
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (load) begin
          ovalid_d = 1'b1;
          if (cur_last) begin
            state_d = ST_IDLE;
          end else begin
            pos_x_d = pos_x_q + inc_x_q;
            pos_y_d = pos_y_q + inc_y_q;
            left_d  = left_q - 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  dda_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .mag_i    (div_mag),
    .divisor_i(state_q == ST_PREP ? steps : steps_q),
    .stat_o   (div_stat),
    .quot_o   (div_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
      width_q  <= SCREEN_W_RST;
      height_q <= SCREEN_H_RST;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_SCREEN_WIDTH)  width_q  <= cfg_data_i;
        if (cfg_index_i == CFG_SCREEN_HEIGHT) height_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      sx_q    <= start_x_i;
      sy_q    <= start_y_i;
      ex_q    <= end_x_i;
      ey_q    <= end_y_i;
      color_q <= line_color_i;
    end
    pos_x_q <= pos_x_d;
    pos_y_q <= pos_y_d;
    inc_x_q <= inc_x_d;
    inc_y_q <= inc_y_d;
    left_q  <= left_d;
    cut_q   <= cut_d;
    neg_x_q <= neg_x_d;
    neg_y_q <= neg_y_d;
    ady_q   <= ady_d;
    steps_q <= steps_d;
    if (load) begin
      px_q     <= cur_px;
      py_q     <= cur_py;
      pcol_q   <= color_q;
      on_q     <= cur_on;
      last_q   <= cur_last;
      cutout_q <= cur_last && cut_q;
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = ovalid_q;
  assign pixel_x_o     = px_q;
  assign pixel_y_o     = py_q;
  assign pixel_color_o = pcol_q;
  assign on_screen_o   = on_q;
  assign last_pixel_o  = last_q;
  assign cut_short_o   = cutout_q;

`ifndef NO_ASSERTIONS
  // cut flag only ever rides on the final pixel
  a_cut_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cut_short_o |-> last_pixel_o)
    else $error("cut_short without last_pixel");

  // divider is never restarted mid-run
  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // an accepted line blocks the input on the next cycle
  a_accept_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // loading the last pixel ends the walk
  a_last_ends_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && cur_last |=> state_q == ST_IDLE && out_valid_o && last_pixel_o)
    else $error("walk did not end on last pixel");
`endif

endmodule
